[rtl/core/tcw_pkg.sv]
// Shared types and constants for the text console writer.
package tcw_pkg;

    // Operation codes on func
    localparam logic [2:0] FN_PUT       = 3'd0;
    localparam logic [2:0] FN_BACKSPACE = 3'd1;
    localparam logic [2:0] FN_BLINK     = 3'd2;
    localparam logic [2:0] FN_CLEAR     = 3'd3;
    localparam logic [2:0] FN_READ      = 3'd4;

    // Character codes
    localparam logic [7:0] CH_NEWLINE        = 8'd10;
    localparam logic [7:0] CH_RETURN         = 8'd13;
    localparam logic [7:0] CH_SPACE          = 8'd32;
    localparam logic [7:0] CH_UNDERSCORE     = 8'd95;
    localparam logic [7:0] CH_LAST_PRINTABLE = 8'd127;

    // Configuration register indexes and reset values
    localparam logic       CFG_FG   = 1'b0;
    localparam logic       CFG_BG   = 1'b1;
    localparam logic [3:0] FG_RESET = 4'd15;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_BS2,
        ST_SWEEP,
        ST_DONE
    } tcw_state_t;

    // Character written at the cursor
    typedef enum logic [1:0] {
        CSEL_SPACE,
        CSEL_CODE,
        CSEL_BLINK
    } tcw_csel_t;

    typedef struct packed {
        logic      item_load;
        logic      wr_cur;
        tcw_csel_t csel;
        logic      cur_advance;
        logic      cur_newline;
        logic      col_clr;
        logic      col_dec;
        logic      blink_step;
        logic      sweep_start;
        logic      sweep_copy;
        logic      cursor_clr;
        logic      rd_issue;
    } tcw_cmd_t;

    typedef struct packed {
        logic col_first;
        logic col_last;
        logic row_last;
        logic blink_hit;
        logic sweep_busy;
    } tcw_stat_t;

endpackage

[rtl/core/tcw_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/tcw_ctrl.sv]
// Controller state machine for the text console writer.
module tcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        func,
    input  logic [7:0]        char_code,
    input  tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t  cmd,
    output logic              busy,
    output logic              done
);

    tcw_pkg::tcw_state_t state_reg;
    tcw_pkg::tcw_state_t state_next;
    logic                printable;

    assign printable = (char_code >= tcw_pkg::CH_SPACE) &&
                       (char_code <= tcw_pkg::CH_LAST_PRINTABLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.csel   = tcw_pkg::CSEL_SPACE;
        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (!stat.sweep_busy)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = tcw_pkg::ST_DONE;
                    unique case (func)
                        tcw_pkg::FN_PUT:
                        begin
                            priority if (char_code == tcw_pkg::CH_NEWLINE)
                            begin
                                cmd.wr_cur      = 1'b1;
                                cmd.csel        = tcw_pkg::CSEL_SPACE;
                                cmd.cur_newline = 1'b1;
                                if (stat.row_last)
                                begin
                                    cmd.sweep_start = 1'b1;
                                    cmd.sweep_copy  = 1'b1;
                                    state_next      = tcw_pkg::ST_SWEEP;
                                end
                            end
                            else if (char_code == tcw_pkg::CH_RETURN)
                            begin
                                cmd.col_clr = 1'b1;
                            end
                            else if (printable)
                            begin
                                cmd.wr_cur      = 1'b1;
                                cmd.csel        = tcw_pkg::CSEL_CODE;
                                cmd.cur_advance = 1'b1;
                                if (stat.col_last && stat.row_last)
                                begin
                                    cmd.sweep_start = 1'b1;
                                    cmd.sweep_copy  = 1'b1;
                                    state_next      = tcw_pkg::ST_SWEEP;
                                end
                            end
                            else
                            begin
                                // other codes are dropped
                                cmd.item_load = 1'b1;
                            end
                        end
                        tcw_pkg::FN_BACKSPACE:
                        begin
                            if (!stat.col_first)
                            begin
                                cmd.wr_cur  = 1'b1;
                                cmd.csel    = tcw_pkg::CSEL_SPACE;
                                cmd.col_dec = 1'b1;
                                state_next  = tcw_pkg::ST_BS2;
                            end
                        end
                        tcw_pkg::FN_BLINK:
                        begin
                            cmd.blink_step = 1'b1;
                            if (stat.blink_hit)
                            begin
                                cmd.wr_cur = 1'b1;
                                cmd.csel   = tcw_pkg::CSEL_BLINK;
                            end
                        end
                        tcw_pkg::FN_CLEAR:
                        begin
                            cmd.cursor_clr  = 1'b1;
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_copy  = 1'b0;
                            state_next      = tcw_pkg::ST_SWEEP;
                        end
                        tcw_pkg::FN_READ:
                        begin
                            cmd.rd_issue = 1'b1;
                        end
                        default:
                        begin
                            cmd.item_load = 1'b1;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_BS2:
            begin
                cmd.wr_cur = 1'b1;
                cmd.csel   = tcw_pkg::CSEL_SPACE;
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SWEEP:
            begin
                if (!stat.sweep_busy)
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != tcw_pkg::ST_IDLE);
    assign done = (state_reg == tcw_pkg::ST_DONE);

endmodule

[rtl/core/tcw_dp.sv]
// Datapath: cursor, blink, colors, buffer sweep and RAM port muxing.
module tcw_dp #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int BLINK_TICKS = 50
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcw_pkg::tcw_cmd_t                   cmd,
    output tcw_pkg::tcw_stat_t                  stat,
    input  logic [7:0]                          char_code,
    input  logic [10:0]                         read_addr,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [3:0]                          cfg_wdata,
    output logic                                ram_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_waddr,
    output logic [15:0]                         ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_raddr,
    input  logic [15:0]                         ram_rdata,
    output logic [15:0]                         cell_data,
    output logic [6:0]                          cursor_col,
    output logic [4:0]                          cursor_row,
    output logic                                cursor_shown
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int KEEP_CELLS = CELL_COUNT - COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int BW         = $clog2(BLINK_TICKS + 1);

    logic [CW-1:0] col_reg,       col_next;
    logic [RW-1:0] row_reg,       row_next;
    logic [BW-1:0] blink_cnt_reg, blink_cnt_next;
    logic          phase_reg,     phase_next;
    logic [3:0]    fg_reg,        fg_next;
    logic [3:0]    bg_reg,        bg_next;
    logic          rd_sel_reg,    rd_sel_next;

    // sweep: read stage at ptr + COLUMNS, write stage at ptr in the cycle after
    logic          sweep_act_reg,  sweep_act_next;
    logic          sweep_copy_reg, sweep_copy_next;
    logic [AW-1:0] ptr_reg,        ptr_next;
    logic          pend_vld_reg,   pend_vld_next;
    logic          pend_ram_reg,   pend_ram_next;
    logic [AW-1:0] pend_addr_reg,  pend_addr_next;

    logic [AW-1:0] cur_idx;
    logic [31:0]   rd_ext;
    logic          rd_in_range;
    logic          ptr_keep;
    logic [7:0]    wr_char;

    assign cur_idx     = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign rd_ext      = 32'(read_addr);
    assign rd_in_range = rd_ext < 32'(CELL_COUNT);
    assign ptr_keep    = ptr_reg < AW'(KEEP_CELLS);

    assign stat.col_first  = (col_reg == '0);
    assign stat.col_last   = (col_reg == CW'(COLUMNS - 1));
    assign stat.row_last   = (row_reg == RW'(ROWS - 1));
    assign stat.blink_hit  = (blink_cnt_reg == BW'(BLINK_TICKS - 1));
    assign stat.sweep_busy = sweep_act_reg | pend_vld_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cmd.cursor_clr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.cur_newline)
        begin
            col_next = '0;
            if (!stat.row_last)
            begin
                row_next = row_reg + RW'(1);
            end
        end
        else if (cmd.cur_advance)
        begin
            if (stat.col_last)
            begin
                col_next = '0;
                if (!stat.row_last)
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        else if (cmd.col_clr)
        begin
            col_next = '0;
        end
        else if (cmd.col_dec)
        begin
            col_next = col_reg - CW'(1);
        end
        else
        begin
            col_next = col_reg;
        end
    end

    always_comb
    begin
        blink_cnt_next = blink_cnt_reg;
        phase_next     = phase_reg;
        if (cmd.blink_step)
        begin
            if (stat.blink_hit)
            begin
                blink_cnt_next = '0;
                phase_next     = ~phase_reg;
            end
            else
            begin
                blink_cnt_next = blink_cnt_reg + BW'(1);
            end
        end
    end

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                tcw_pkg::CFG_FG: fg_next = cfg_wdata;
                tcw_pkg::CFG_BG: bg_next = cfg_wdata;
                default:         fg_next = fg_reg;
            endcase
        end
    end

    assign rd_sel_next = cmd.item_load ? (cmd.rd_issue & rd_in_range) : rd_sel_reg;

    always_comb
    begin
        sweep_act_next  = sweep_act_reg;
        sweep_copy_next = sweep_copy_reg;
        ptr_next        = ptr_reg;
        if (cmd.sweep_start)
        begin
            sweep_act_next  = 1'b1;
            sweep_copy_next = cmd.sweep_copy;
            ptr_next        = '0;
        end
        else if (sweep_act_reg)
        begin
            ptr_next = ptr_reg + AW'(1);
            if (ptr_reg == AW'(CELL_COUNT - 1))
            begin
                sweep_act_next = 1'b0;
            end
        end
        pend_vld_next  = sweep_act_reg;
        pend_addr_next = ptr_reg;
        pend_ram_next  = sweep_copy_reg & ptr_keep;
    end

    always_comb
    begin
        unique case (cmd.csel)
            tcw_pkg::CSEL_SPACE: wr_char = tcw_pkg::CH_SPACE;
            tcw_pkg::CSEL_CODE:  wr_char = char_code;
            tcw_pkg::CSEL_BLINK:
                wr_char = phase_reg ? tcw_pkg::CH_UNDERSCORE : tcw_pkg::CH_SPACE;
            default:             wr_char = tcw_pkg::CH_SPACE;
        endcase
    end

    // RAM ports: the sweep owns them while it runs
    always_comb
    begin
        if (pend_vld_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_ram_reg ? ram_rdata : 16'h0000;
        end
        else
        begin
            ram_we    = cmd.wr_cur;
            ram_waddr = cur_idx;
            ram_wdata = {bg_reg, fg_reg, wr_char};
        end
        if (sweep_act_reg && sweep_copy_reg && ptr_keep)
        begin
            ram_re    = 1'b1;
            ram_raddr = ptr_reg + AW'(COLUMNS);
        end
        else
        begin
            ram_re    = cmd.rd_issue & rd_in_range;
            ram_raddr = rd_ext[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            blink_cnt_reg  <= '0;
            phase_reg      <= 1'b0;
            fg_reg         <= tcw_pkg::FG_RESET;
            bg_reg         <= tcw_pkg::BG_RESET;
            rd_sel_reg     <= 1'b0;
            sweep_act_reg  <= 1'b1;   // clearing pass starts out of reset
            sweep_copy_reg <= 1'b0;
            ptr_reg        <= '0;
            pend_vld_reg   <= 1'b0;
            pend_ram_reg   <= 1'b0;
            pend_addr_reg  <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            blink_cnt_reg  <= blink_cnt_next;
            phase_reg      <= phase_next;
            fg_reg         <= fg_next;
            bg_reg         <= bg_next;
            rd_sel_reg     <= rd_sel_next;
            sweep_act_reg  <= sweep_act_next;
            sweep_copy_reg <= sweep_copy_next;
            ptr_reg        <= ptr_next;
            pend_vld_reg   <= pend_vld_next;
            pend_ram_reg   <= pend_ram_next;
            pend_addr_reg  <= pend_addr_next;
        end
    end

    assign cell_data    = rd_sel_reg ? ram_rdata : 16'h0000;
    assign cursor_col   = 7'(col_reg);
    assign cursor_row   = 5'(row_reg);
    assign cursor_shown = phase_reg;

endmodule

[rtl/core/text_console_writer_top.sv]
// Top level of the text console writer: controller, datapath and cell RAM.
//
// Text-mode console engine holding a COLUMNS x ROWS buffer of 16-bit cells
// (background nibble, foreground nibble, character). An operation is taken
// when start is high and busy is low; its single result shows on cell_data,
// cursor_col, cursor_row and cursor_shown for exactly one cycle with done
// high, and the receiver cannot stall that transfer. Put, carriage return,
// ignored codes, blink tick, read and unused codes pass from the accept
// cycle straight to the result cycle; backspace takes an extra state, since
// the two blanked cells share the single RAM write port, but not at column
// zero where nothing is written. A put that scrolls and a clear walk the
// whole buffer through the RAM, one cell per cycle, before the result.
// After reset the block runs the same zeroing pass and holds busy high
// until it ends, before the first operation is taken; configuration
// writes are taken at any time, including during that pass.
// Colors are written through cfg_we / cfg_addr (0 foreground, 1 background)
// / cfg_wdata and apply to every cell written at the cursor afterwards.
module text_console_writer_top #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int BLINK_TICKS = 50
) (
    input  logic        clk,
    input  logic        rst_n,
    // command transfer
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [7:0]  char_code,
    input  logic [10:0] read_addr,
    // result transfer, one cycle, no back-pressure
    output logic        done,
    output logic [15:0] cell_data,
    output logic [6:0]  cursor_col,
    output logic [4:0]  cursor_row,
    output logic        cursor_shown,
    // color registers
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);

    tcw_pkg::tcw_cmd_t  cmd;
    tcw_pkg::tcw_stat_t stat;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // Sequencing: decodes each operation and waits out sweeps.
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .char_code (char_code),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    // Cursor, blink and color state; owns both RAM ports.
    tcw_dp #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .BLINK_TICKS (BLINK_TICKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .char_code    (char_code),
        .read_addr    (read_addr),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .cell_data    (cell_data),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .cursor_shown (cursor_shown)
    );

    // Character buffer. Scroll reads each cell of row r+1 the cycle before writing it into row r.
    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[rtl/core/tcw_checker.sv]
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [6:0] cursor_col,
    input logic [4:0] cursor_row
);

    // result only while the operation is still held
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // after the result the block is free again
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result");

    // a taken command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but not busy");

    // reported cursor stays inside the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((32'(cursor_col) < COLUMNS) && (32'(cursor_row) < ROWS)))
        else $error("cursor out of range");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
);

[dv/text_console_checker.sv]
// Scoreboard for the text console writer: predicts every result and checks it.
`timescale 1ns / 1ps

module text_console_checker #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int BLINK_TICKS = 50
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  func,
    input  logic [7:0]  char_code,
    input  logic [10:0] read_addr,
    input  logic        done,
    input  logic [15:0] cell_data,
    input  logic [6:0]  cursor_col,
    input  logic [4:0]  cursor_row,
    input  logic        cursor_shown,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata,
    output int          outstanding,
    output int          mismatches
);

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [15:0] data;
        logic [6:0]  col;
        logic [4:0]  row;
        logic        shown;
    } console_report_t;

    // Shadow copy of the console
    logic [15:0] shadow_cells [CELLS];
    int          col_pos;
    int          row_pos;
    int          blink_count;
    logic        blink_phase;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;

    console_report_t awaited_reports [$];

    initial mismatches = 0;

    function automatic void put_cell(int col, int row, logic [7:0] ch);
        int idx;
        idx = row * COLUMNS + col;
        if (col < COLUMNS && idx < CELLS)
        begin
            shadow_cells[idx] = {bg_color, fg_color, ch};
        end
    endfunction

    function automatic void scroll_up();
        for (int i = 0; i < CELLS - COLUMNS; i++)
        begin
            shadow_cells[i] = shadow_cells[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
        begin
            shadow_cells[i] = '0;
        end
        row_pos = ROWS - 1;
        col_pos = 0;
    endfunction

    function automatic void put_char(logic [7:0] code);
        if (code == tcw_pkg::CH_NEWLINE)
        begin
            put_cell(col_pos, row_pos, tcw_pkg::CH_SPACE);
            row_pos++;
            col_pos = 0;
        end
        else if (code == tcw_pkg::CH_RETURN)
        begin
            col_pos = 0;
        end
        else if (code >= tcw_pkg::CH_SPACE && code <= tcw_pkg::CH_LAST_PRINTABLE)
        begin
            put_cell(col_pos, row_pos, code);
            col_pos++;
            if (col_pos >= COLUMNS)
            begin
                col_pos = 0;
                row_pos++;
            end
        end
        if (row_pos >= ROWS)
        begin
            scroll_up();
        end
    endfunction

    function automatic console_report_t console_step(logic [2:0] op, logic [7:0] code,
                                                     logic [10:0] addr);
        console_report_t r;
        r.data = '0;
        case (op)
            tcw_pkg::FN_PUT:
                put_char(code);
            tcw_pkg::FN_BACKSPACE:
                if (col_pos > 0)
                begin
                    put_cell(col_pos, row_pos, tcw_pkg::CH_SPACE);
                    col_pos--;
                    put_cell(col_pos, row_pos, tcw_pkg::CH_SPACE);
                end
            tcw_pkg::FN_BLINK:
            begin
                blink_count++;
                if (blink_count >= BLINK_TICKS)
                begin
                    put_cell(col_pos, row_pos,
                             blink_phase ? tcw_pkg::CH_UNDERSCORE : tcw_pkg::CH_SPACE);
                    blink_phase = ~blink_phase;
                    blink_count = 0;
                end
            end
            tcw_pkg::FN_CLEAR:
            begin
                shadow_cells = '{default: '0};
                col_pos = 0;
                row_pos = 0;
            end
            tcw_pkg::FN_READ:
                if (addr < CELLS)
                begin
                    r.data = shadow_cells[addr];
                end
            default: ;
        endcase
        r.col   = col_pos[6:0];
        r.row   = row_pos[4:0];
        r.shown = blink_phase;
        return r;
    endfunction

    function automatic void flag_mismatch(string what, console_report_t want,
                                          console_report_t got);
        if (mismatches < 10)
        begin
            $display("%0t: %s: exp data=%h col=%0d row=%0d shown=%b", $time, what,
                     want.data, want.col, want.row, want.shown);
            $display("%0t: %s: got data=%h col=%0d row=%0d shown=%b", $time, what,
                     got.data, got.col, got.row, got.shown);
        end
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        console_report_t got;
        console_report_t want;
        if (!rst_n)
        begin
            shadow_cells = '{default: '0};
            col_pos     = 0;
            row_pos     = 0;
            blink_count = 0;
            blink_phase = 1'b0;
            fg_color    = tcw_pkg::FG_RESET;
            bg_color    = tcw_pkg::BG_RESET;
            awaited_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == tcw_pkg::CFG_FG)
                    fg_color = cfg_wdata;
                else
                    bg_color = cfg_wdata;
            end
            // results first, so a result never pairs with the op taken at this edge
            if (done)
            begin
                got = '{cell_data, cursor_col, cursor_row, cursor_shown};
                if (awaited_reports.size() == 0)
                begin
                    flag_mismatch("unexpected result", '0, got);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got.data != want.data || got.col != want.col ||
                        got.row != want.row || got.shown != want.shown)
                    begin
                        flag_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (start && !busy)
            begin
                awaited_reports.push_back(console_step(func, char_code, read_addr));
            end
            outstanding <= awaited_reports.size();
        end
    end

endmodule

[dv/tb_text_console_writer_top.sv]
// Testbench top for the text console writer: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_text_console_writer_top;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int BLINK_TICKS = 50;
    localparam int CELLS       = COLUMNS * ROWS;

    // Stop once this many ops that actually do something have gone in.
    localparam int ITEM_TARGET = 1100;
    localparam int PHASES      = 5;

    // A scroll or clear keeps busy high for a whole buffer sweep, as does the
    // post-reset zeroing pass; a long silence is anything well past that.
    localparam int WATCHDOG_CYCLES = 8 * (CELLS + 4) + 200;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [2:0]  func      = '0;
    logic [7:0]  char_code = '0;
    logic [10:0] read_addr = '0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [3:0]  cfg_wdata = '0;

    logic        busy;
    logic        done;
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        cursor_shown;

    int outstanding;
    int mismatches;

    int         counted_ops  = 0;
    int         quiet_cycles = 0;
    bit         steady       = 1'b0;  // no gaps for the current segment
    logic [4:0] recent_row   = '0;    // last cursor row reported, steers reads

    text_console_writer_top #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .BLINK_TICKS (BLINK_TICKS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .char_code    (char_code),
        .read_addr    (read_addr),
        .done         (done),
        .cell_data    (cell_data),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .cursor_shown (cursor_shown),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    text_console_checker #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .BLINK_TICKS (BLINK_TICKS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .char_code    (char_code),
        .read_addr    (read_addr),
        .done         (done),
        .cell_data    (cell_data),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .cursor_shown (cursor_shown),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Track where the cursor sits so reads land on freshly written rows.
    always @(posedge clk)
    begin
        if (done)
            recent_row <= cursor_row;
    end

    // Watchdog: a transfer in either direction restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One command transfer. Start is left high on return, so a back-to-back
    // op keeps it asserted without a drop in between; callers that pause
    // lower it themselves.
    task automatic send_op(input logic [2:0] op, input logic [7:0] code,
                           input logic [10:0] addr);
        int gap;
        gap = steady ? 0 : int'($urandom_range(0, 13));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        func      <= op;
        char_code <= code;
        read_addr <= addr;
        do
            @(posedge clk);
        while (busy);
        // ignored codes and unused functions don't count toward the target
        if (op == tcw_pkg::FN_READ || op == tcw_pkg::FN_BACKSPACE ||
            op == tcw_pkg::FN_BLINK || op == tcw_pkg::FN_CLEAR ||
            (op == tcw_pkg::FN_PUT &&
             (code == tcw_pkg::CH_NEWLINE || code == tcw_pkg::CH_RETURN ||
              (code >= tcw_pkg::CH_SPACE && code <= tcw_pkg::CH_LAST_PRINTABLE))))
        begin
            counted_ops++;
        end
    endtask

    // Stop sending and wait for every awaited result to come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Colors are changed with the block idle only between phases; the first call falls in the post-reset zeroing pass.
    task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= tcw_pkg::CFG_FG;
        cfg_wdata <= fg;
        @(posedge clk);
        cfg_addr  <= tcw_pkg::CFG_BG;
        cfg_wdata <= bg;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Half the time the rows around the cursor, then anything the port allows,
    // then the edges of the buffer and just past it.
    function automatic logic [10:0] pick_addr();
        int sel;
        int r;
        sel = int'($urandom_range(0, 19));
        if (sel < 10)
        begin
            r = int'(recent_row) - int'($urandom_range(0, 2));
            if (r < 0)
                r = 0;
            return 11'(r * COLUMNS + int'($urandom_range(0, COLUMNS - 1)));
        end
        else if (sel < 17)
        begin
            return 11'($urandom_range(0, 2047));
        end
        case ($urandom_range(0, 5))
            0:       return 11'(0);
            1:       return 11'(CELLS - 1);
            2:       return 11'(CELLS);
            3:       return 11'(2047);
            4:       return 11'(CELLS - COLUMNS);
            default: return 11'(COLUMNS - 1);
        endcase
    endfunction

    function automatic logic [7:0] any_code();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(tcw_pkg::CH_SPACE, tcw_pkg::CH_LAST_PRINTABLE));
    endfunction

    // One burst of related traffic. Text lines and newline runs push the
    // cursor down so the buffer scrolls; blink bursts are long enough to
    // cross the tick threshold now and then.
    task automatic run_segment();
        int kind;
        int n;
        int pick;
        kind   = $urandom_range(0, 99);
        steady = ($urandom_range(0, 3) == 0);
        if (kind < 35)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                n = $urandom_range(0, 10);
            else if (pick < 9)
                n = $urandom_range(11, COLUMNS - 1);
            else
                n = $urandom_range(COLUMNS, COLUMNS + 20);  // runs past the row end
            repeat (n) send_op(tcw_pkg::FN_PUT, printable(), pick_addr());
            pick = $urandom_range(0, 3);
            if (pick < 2)
                send_op(tcw_pkg::FN_PUT, tcw_pkg::CH_NEWLINE, pick_addr());
            else if (pick == 2)
                send_op(tcw_pkg::FN_PUT, tcw_pkg::CH_RETURN, pick_addr());
        end
        else if (kind < 45)
        begin
            repeat ($urandom_range(1, 6))
                send_op(tcw_pkg::FN_PUT, tcw_pkg::CH_NEWLINE, pick_addr());
        end
        else if (kind < 55)
        begin
            repeat ($urandom_range(10, 60))
                send_op(tcw_pkg::FN_BLINK, any_code(), pick_addr());
        end
        else if (kind < 68)
        begin
            repeat ($urandom_range(1, 5))
            begin
                send_op(tcw_pkg::FN_BACKSPACE, any_code(), pick_addr());
                if ($urandom_range(0, 2) == 0)
                    send_op(tcw_pkg::FN_PUT, printable(), pick_addr());
            end
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 8)) send_op(tcw_pkg::FN_READ, any_code(), pick_addr());
        end
        else if (kind < 98)
        begin
            // noise: any function code, any character, any address
            repeat ($urandom_range(1, 4))
                send_op(3'($urandom_range(0, 7)), any_code(), 11'($urandom_range(0, 2047)));
        end
        else
        begin
            send_op(tcw_pkg::FN_CLEAR, any_code(), pick_addr());
        end
    endtask

    initial
    begin
        int p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_colors(4'd7, 4'd9);

        // Directed: address and code extremes, each function, the odd cases.
        send_op(tcw_pkg::FN_READ, 8'd0, 11'd0);
        send_op(tcw_pkg::FN_READ, 8'd255, 11'd2047);          // far out of range
        send_op(tcw_pkg::FN_READ, any_code(), 11'(CELLS - 1));
        send_op(tcw_pkg::FN_READ, any_code(), 11'(CELLS));    // first address past the end
        send_op(tcw_pkg::FN_PUT, 8'd65, pick_addr());
        send_op(tcw_pkg::FN_PUT, tcw_pkg::CH_SPACE, pick_addr());
        send_op(tcw_pkg::FN_PUT, tcw_pkg::CH_LAST_PRINTABLE, pick_addr());
        send_op(tcw_pkg::FN_PUT, 8'd0, 11'd0);                // control codes are dropped
        send_op(tcw_pkg::FN_PUT, 8'd255, 11'd2047);           // high half is dropped
        send_op(tcw_pkg::FN_PUT, 8'd128, pick_addr());
        send_op(tcw_pkg::FN_PUT, 8'd31, pick_addr());
        send_op(tcw_pkg::FN_READ, any_code(), 11'd0);
        send_op(tcw_pkg::FN_READ, any_code(), 11'd2);
        send_op(tcw_pkg::FN_BACKSPACE, any_code(), pick_addr());
        send_op(tcw_pkg::FN_PUT, tcw_pkg::CH_RETURN, pick_addr());
        send_op(tcw_pkg::FN_BACKSPACE, any_code(), pick_addr());  // at column zero: no effect
        send_op(tcw_pkg::FN_PUT, tcw_pkg::CH_NEWLINE, pick_addr());
        send_op(tcw_pkg::FN_BLINK, any_code(), pick_addr());
        send_op(3'd5, any_code(), pick_addr());          // unused function codes
        send_op(3'd7, 8'd255, 11'd2047);
        send_op(tcw_pkg::FN_READ, any_code(), 11'd1);
        send_op(tcw_pkg::FN_CLEAR, any_code(), pick_addr());
        send_op(tcw_pkg::FN_READ, any_code(), 11'd1);

        // Random phases, each with its own colors; idle before every change.
        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1:       write_colors(4'd15, 4'd15);
                    2:       write_colors(4'd0, 4'd0);
                    3:       write_colors(4'd0, 4'd15);
                    default: write_colors(4'($urandom_range(0, 15)),
                                          4'($urandom_range(0, 15)));
                endcase
            end
            while (counted_ops < (p + 1) * ITEM_TARGET / PHASES)
            begin
                run_segment();
                // now and then hold off until the block has nothing in flight
                if ($urandom_range(0, 19) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dp.sv
rtl/core/text_console_writer_top.sv
rtl/core/tcw_checker.sv
dv/text_console_checker.sv
dv/tb_text_console_writer_top.sv
